// ===== rtl/tgpr_pkg.sv =====
package tgpr_pkg;

    // font and cell geometry
    localparam int GLYPH_COUNT = 95;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam int CELL_WIDTH  = 6;
    localparam int LINE_PITCH  = 9;

    // character codes
    localparam logic [7:0] FIRST_CODE = 8'h20;
    localparam logic [7:0] LAST_CODE  = 8'h7E;
    localparam logic [7:0] SUBST_CODE = 8'h3F;
    localparam logic [7:0] END_CODE   = 8'h00;

    // configuration register indexes
    typedef enum logic {
        CFG_PANEL_WIDTH  = 1'b0,
        CFG_PANEL_HEIGHT = 1'b1
    } t_cfg_index;

    localparam logic [9:0] PANEL_WIDTH_RESET  = 10'd142;
    localparam logic [9:0] PANEL_HEIGHT_RESET = 10'd428;

    // one glyph: element c holds column (GLYPH_COLS-1-c), bit r is row r
    typedef logic [GLYPH_COLS-1:0][6:0] t_glyph;

    typedef struct packed {
        logic [7:0]  char_code;
        logic        string_start;
        logic [9:0]  origin_x;
        logic [9:0]  origin_y;
        logic [15:0] ink_color;
        logic [15:0] paper_color;
    } t_char;

    typedef struct packed {
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
        logic [15:0] pixel_colour;
        logic        last_of_char;
    } t_pixel;

    // 5x7 column font, codes 0x20..0x7e
    localparam t_glyph GLYPH_ROM [GLYPH_COUNT] = '{
        {7'h00,7'h00,7'h00,7'h00,7'h00},{7'h00,7'h00,7'h5F,7'h00,7'h00},
        {7'h00,7'h07,7'h00,7'h07,7'h00},{7'h14,7'h7F,7'h14,7'h7F,7'h14},
        {7'h24,7'h2A,7'h7F,7'h2A,7'h12},{7'h23,7'h13,7'h08,7'h64,7'h62},
        {7'h36,7'h49,7'h55,7'h22,7'h50},{7'h00,7'h05,7'h03,7'h00,7'h00},
        {7'h00,7'h1C,7'h22,7'h41,7'h00},{7'h00,7'h41,7'h22,7'h1C,7'h00},
        {7'h08,7'h2A,7'h1C,7'h2A,7'h08},{7'h08,7'h08,7'h3E,7'h08,7'h08},
        {7'h00,7'h50,7'h30,7'h00,7'h00},{7'h08,7'h08,7'h08,7'h08,7'h08},
        {7'h00,7'h60,7'h60,7'h00,7'h00},{7'h20,7'h10,7'h08,7'h04,7'h02},
        {7'h3E,7'h51,7'h49,7'h45,7'h3E},{7'h00,7'h42,7'h7F,7'h40,7'h00},
        {7'h42,7'h61,7'h51,7'h49,7'h46},{7'h21,7'h41,7'h45,7'h4B,7'h31},
        {7'h18,7'h14,7'h12,7'h7F,7'h10},{7'h27,7'h45,7'h45,7'h45,7'h39},
        {7'h3C,7'h4A,7'h49,7'h49,7'h30},{7'h01,7'h71,7'h09,7'h05,7'h03},
        {7'h36,7'h49,7'h49,7'h49,7'h36},{7'h06,7'h49,7'h49,7'h29,7'h1E},
        {7'h00,7'h36,7'h36,7'h00,7'h00},{7'h00,7'h56,7'h36,7'h00,7'h00},
        {7'h08,7'h14,7'h22,7'h41,7'h00},{7'h14,7'h14,7'h14,7'h14,7'h14},
        {7'h00,7'h41,7'h22,7'h14,7'h08},{7'h02,7'h01,7'h51,7'h09,7'h06},
        {7'h32,7'h49,7'h79,7'h41,7'h3E},{7'h7E,7'h11,7'h11,7'h11,7'h7E},
        {7'h7F,7'h49,7'h49,7'h49,7'h36},{7'h3E,7'h41,7'h41,7'h41,7'h22},
        {7'h7F,7'h41,7'h41,7'h22,7'h1C},{7'h7F,7'h49,7'h49,7'h49,7'h41},
        {7'h7F,7'h09,7'h09,7'h09,7'h01},{7'h3E,7'h41,7'h49,7'h49,7'h7A},
        {7'h7F,7'h08,7'h08,7'h08,7'h7F},{7'h00,7'h41,7'h7F,7'h41,7'h00},
        {7'h20,7'h40,7'h41,7'h3F,7'h01},{7'h7F,7'h08,7'h14,7'h22,7'h41},
        {7'h7F,7'h40,7'h40,7'h40,7'h40},{7'h7F,7'h02,7'h04,7'h02,7'h7F},
        {7'h7F,7'h04,7'h08,7'h10,7'h7F},{7'h3E,7'h41,7'h41,7'h41,7'h3E},
        {7'h7F,7'h09,7'h09,7'h09,7'h06},{7'h3E,7'h41,7'h51,7'h21,7'h5E},
        {7'h7F,7'h09,7'h19,7'h29,7'h46},{7'h46,7'h49,7'h49,7'h49,7'h31},
        {7'h01,7'h01,7'h7F,7'h01,7'h01},{7'h3F,7'h40,7'h40,7'h40,7'h3F},
        {7'h1F,7'h20,7'h40,7'h20,7'h1F},{7'h3F,7'h40,7'h38,7'h40,7'h3F},
        {7'h63,7'h14,7'h08,7'h14,7'h63},{7'h07,7'h08,7'h70,7'h08,7'h07},
        {7'h61,7'h51,7'h49,7'h45,7'h43},{7'h00,7'h7F,7'h41,7'h41,7'h00},
        {7'h02,7'h04,7'h08,7'h10,7'h20},{7'h00,7'h41,7'h41,7'h7F,7'h00},
        {7'h04,7'h02,7'h01,7'h02,7'h04},{7'h40,7'h40,7'h40,7'h40,7'h40},
        {7'h00,7'h01,7'h02,7'h04,7'h00},{7'h20,7'h54,7'h54,7'h54,7'h78},
        {7'h7F,7'h48,7'h44,7'h44,7'h38},{7'h38,7'h44,7'h44,7'h44,7'h20},
        {7'h38,7'h44,7'h44,7'h48,7'h7F},{7'h38,7'h54,7'h54,7'h54,7'h18},
        {7'h08,7'h7E,7'h09,7'h01,7'h02},{7'h0C,7'h52,7'h52,7'h52,7'h3E},
        {7'h7F,7'h08,7'h04,7'h04,7'h78},{7'h00,7'h44,7'h7D,7'h40,7'h00},
        {7'h20,7'h40,7'h44,7'h3D,7'h00},{7'h7F,7'h10,7'h28,7'h44,7'h00},
        {7'h00,7'h41,7'h7F,7'h40,7'h00},{7'h7C,7'h04,7'h18,7'h04,7'h78},
        {7'h7C,7'h08,7'h04,7'h04,7'h78},{7'h38,7'h44,7'h44,7'h44,7'h38},
        {7'h7C,7'h14,7'h14,7'h14,7'h08},{7'h08,7'h14,7'h14,7'h18,7'h7C},
        {7'h7C,7'h08,7'h04,7'h04,7'h08},{7'h48,7'h54,7'h54,7'h54,7'h20},
        {7'h04,7'h3F,7'h44,7'h40,7'h20},{7'h3C,7'h40,7'h40,7'h40,7'h7C},
        {7'h1C,7'h20,7'h40,7'h20,7'h1C},{7'h3C,7'h40,7'h30,7'h40,7'h3C},
        {7'h44,7'h28,7'h10,7'h28,7'h44},{7'h0C,7'h50,7'h50,7'h50,7'h3C},
        {7'h44,7'h64,7'h54,7'h4C,7'h44},{7'h00,7'h08,7'h36,7'h41,7'h00},
        {7'h00,7'h00,7'h7F,7'h00,7'h00},{7'h00,7'h41,7'h36,7'h08,7'h00},
        {7'h08,7'h08,7'h2A,7'h1C,7'h08}
    };

endpackage

// ===== rtl/tgpr_glyph_rom.sv =====
module tgpr_glyph_rom (
    input  logic [7:0]      i_code,
    output tgpr_pkg::t_glyph o_glyph
);
    import tgpr_pkg::*;

    logic [7:0] w_code;
    logic [6:0] w_idx;

    // non-printable codes render as the substitute glyph
    always_comb begin
        if (i_code < FIRST_CODE || i_code > LAST_CODE) begin
            w_code = SUBST_CODE;
        end else begin
            w_code = i_code;
        end
    end

    assign w_idx   = 7'(w_code - FIRST_CODE);
    assign o_glyph = GLYPH_ROM[w_idx];

endmodule

// ===== rtl/text_glyph_pixel_renderer_top.sv =====
// an accepted character passes the wrap and bound states, then its pixels are drawn and registered
// throughput: one pixel per cycle while the output does not stall, up to 42 pixels per character;
//   no new character is taken until the current one is drawn, dropped or fully clipped
// terminators and stopped strings retire from idle; a character past the bottom edge is dropped
// reset: synchronous active low; clears the cursor, stops the string, restores panel size
module text_glyph_pixel_renderer_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tgpr_pkg::t_char   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tgpr_pkg::t_pixel  o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [9:0]        i_cfg_data
);
    import tgpr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRAP,
        ST_BOUND,
        ST_DRAW
    } t_state;

    t_state      r_state;
    logic [9:0]  r_width;
    logic [9:0]  r_height;
    logic [10:0] r_cursor_x;
    logic [10:0] r_cursor_y;
    logic [9:0]  r_line_start_x;
    logic        r_stopped;
    logic [15:0] r_fg;
    logic [15:0] r_bg;
    logic [7:0]  r_code;
    t_glyph      r_glyph;
    logic [2:0]  r_col;
    logic [2:0]  r_row;
    logic        r_out_valid;
    t_pixel      r_out_data;

    t_glyph      w_rom_glyph;
    logic [11:0] w_sum;
    logic [11:0] w_sum_next;
    logic        w_clipped;
    logic        w_last;
    logic        w_bit;
    logic        w_out_free;
    logic        w_live;
    logic        w_emit;

    tgpr_glyph_rom u_rom (
        .i_code  (r_code),
        .o_glyph (w_rom_glyph)
    );

    // shared column adder: pixel column and its lookahead for the last visible pixel
    assign w_sum      = {1'b0, r_cursor_x} + 12'(r_col);
    assign w_sum_next = w_sum + 12'd1;
    assign w_clipped  = w_sum >= {2'b00, r_width};
    assign w_last     = (r_row == 3'(GLYPH_ROWS - 1))
                     && ((r_col == 3'(GLYPH_COLS)) || (w_sum_next >= {2'b00, r_width}));

    // glyph bit at the current column and row; the gap column is background
    always_comb begin
        if (r_col == 3'(GLYPH_COLS)) begin
            w_bit = 1'b0;
        end else begin
            w_bit = r_glyph[3'(GLYPH_COLS - 1) - r_col][r_row];
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_live     = i_in_data.string_start || !r_stopped;
    assign w_emit     = (r_state == ST_DRAW) && !w_clipped && w_out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // sequencer, cursor state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_width        <= PANEL_WIDTH_RESET;
            r_height       <= PANEL_HEIGHT_RESET;
            r_cursor_x     <= '0;
            r_cursor_y     <= '0;
            r_line_start_x <= '0;
            r_stopped      <= 1'b1;
            r_fg           <= '0;
            r_bg           <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_valid) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_PANEL_WIDTH:  r_width  <= i_cfg_data;
                    CFG_PANEL_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end

            // output register: loaded by a drawn pixel, freed by a transfer
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in_data.string_start) begin
                            r_line_start_x <= i_in_data.origin_x;
                            r_cursor_x     <= {1'b0, i_in_data.origin_x};
                            r_cursor_y     <= {1'b0, i_in_data.origin_y};
                            r_fg           <= i_in_data.ink_color;
                            r_bg           <= i_in_data.paper_color;
                        end
                        if (i_in_data.char_code == END_CODE) begin
                            r_stopped <= 1'b1;
                        end else begin
                            if (i_in_data.string_start) begin
                                r_stopped <= 1'b0;
                            end
                            if (w_live) begin
                                r_code  <= i_in_data.char_code;
                                r_state <= ST_WRAP;
                            end
                        end
                    end
                end
                ST_WRAP: begin
                    // wrap before a glyph that would cross the right edge
                    if ({1'b0, r_cursor_x} + 12'(CELL_WIDTH) > {2'b00, r_width}) begin
                        r_cursor_x <= {1'b0, r_line_start_x};
                        r_cursor_y <= r_cursor_y + 11'(LINE_PITCH);
                    end
                    r_glyph <= w_rom_glyph;
                    r_state <= ST_BOUND;
                end
                ST_BOUND: begin
                    // stop the string at the bottom edge
                    if ({1'b0, r_cursor_y} + 12'(GLYPH_ROWS) > {2'b00, r_height}) begin
                        r_stopped <= 1'b1;
                        r_state   <= ST_IDLE;
                    end else begin
                        r_col   <= '0;
                        r_row   <= '0;
                        r_state <= ST_DRAW;
                    end
                end
                ST_DRAW: begin
                    // rows never clip after the bound test; the rest of a clipped column is too
                    if (w_clipped) begin
                        r_cursor_x <= r_cursor_x + 11'(CELL_WIDTH);
                        r_state    <= ST_IDLE;
                    end else if (w_out_free) begin
                        r_out_data.pixel_x      <= w_sum[9:0];
                        r_out_data.pixel_y      <= 10'(r_cursor_y + 11'(r_row));
                        r_out_data.pixel_colour <= w_bit ? r_fg : r_bg;
                        r_out_data.last_of_char <= w_last;
                        if (w_last) begin
                            r_cursor_x <= r_cursor_x + 11'(CELL_WIDTH);
                            r_state    <= ST_IDLE;
                        end else if (r_row == 3'(GLYPH_ROWS - 1)) begin
                            r_row <= '0;
                            r_col <= r_col + 3'd1;
                        end else begin
                            r_row <= r_row + 3'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== tb/tb_text_glyph_pixel_renderer_top.sv =====
module tb_text_glyph_pixel_renderer_top;

    import tgpr_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SETTLE_LIMIT = 50000;

    // 5x7 font, one word per glyph: column 0 in the top byte, bit r of a byte is row r
    localparam logic [39:0] FONT_5X7 [95] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700,
        40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
        40'h3649552250, 40'h0005030000, 40'h001C224100,
        40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
        40'h4261514946, 40'h2141454B31, 40'h1814127F10,
        40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000,
        40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413E,
        40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
        40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
        40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
        40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
        40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
        40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204,
        40'h4040404040, 40'h0001020400, 40'h2054545478,
        40'h7F48444438, 40'h3844444420, 40'h384444487F,
        40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
        40'h7C08040478, 40'h3844444438, 40'h7C14141408,
        40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040407C, 40'h1C2040201C,
        40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0008364100, 40'h00007F0000,
        40'h0041360800, 40'h08082A1C08
    };

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_char       i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_pixel      o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [9:0]  i_cfg_data  = '0;

    // renderer state as seen from outside
    logic [9:0]  model_width  = PANEL_WIDTH_RESET;
    logic [9:0]  model_height = PANEL_HEIGHT_RESET;
    logic [10:0] text_x       = '0;
    logic [10:0] text_y       = '0;
    logic [9:0]  line_x       = '0;
    logic        text_stopped = 1'b1;
    logic [15:0] fg_latched   = '0;
    logic [15:0] bg_latched   = '0;

    t_pixel pending_pixels[$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int stall_hold_req  = 0;
    int stall_hold_left = 0;
    int cycle_count     = 0;
    int mismatch_count  = 0;

    text_glyph_pixel_renderer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL text_glyph_pixel_renderer_top");
            $finish;
        end
    end

    // pixel sink: random stall, or a long hold-off counted here
    always @(posedge i_clk) begin
        if (stall_hold_req != 0) begin
            stall_hold_left = stall_hold_req;
            stall_hold_req  = 0;
        end
        if (stall_hold_left != 0) begin
            stall_hold_left = stall_hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // compare each pixel transfer with the oldest expected pixel
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel: actual x=%0d y=%0d colour=%h last=%0b",
                         $time, o_out_data.pixel_x, o_out_data.pixel_y,
                         o_out_data.pixel_colour, o_out_data.last_of_char);
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_out_data.pixel_x !== want.pixel_x ||
                    o_out_data.pixel_y !== want.pixel_y ||
                    o_out_data.pixel_colour !== want.pixel_colour ||
                    o_out_data.last_of_char !== want.last_of_char) begin
                    $display({"%0t: pixel mismatch: expected x=%0d y=%0d colour=%h last=%0b,",
                              " actual x=%0d y=%0d colour=%h last=%0b"},
                             $time, want.pixel_x, want.pixel_y, want.pixel_colour,
                             want.last_of_char, o_out_data.pixel_x, o_out_data.pixel_y,
                             o_out_data.pixel_colour, o_out_data.last_of_char);
                    mismatch_count++;
                end
            end
        end
    end

    // cursor, wrap, stop and clipping rules; queues the pixels of one character
    function automatic void render_glyph_pixels(input t_char ch);
        logic [7:0]  code;
        logic [39:0] glyph;
        logic [7:0]  column_bits;
        int          px;
        int          py;
        t_pixel      held;
        bit          have_held;
        have_held = 1'b0;
        held      = '0;
        if (ch.string_start) begin
            line_x       = ch.origin_x;
            text_x       = {1'b0, ch.origin_x};
            text_y       = {1'b0, ch.origin_y};
            fg_latched   = ch.ink_color;
            bg_latched   = ch.paper_color;
            text_stopped = 1'b0;
        end
        if (ch.char_code == END_CODE) begin
            text_stopped = 1'b1;
            return;
        end
        if (text_stopped)
            return;
        if (int'(text_x) + CELL_WIDTH > int'(model_width)) begin
            text_x = {1'b0, line_x};
            text_y = text_y + 11'(LINE_PITCH);
        end
        if (int'(text_y) + GLYPH_ROWS > int'(model_height)) begin
            text_stopped = 1'b1;
            return;
        end
        code = ch.char_code;
        if (code < FIRST_CODE || code > LAST_CODE)
            code = SUBST_CODE;
        glyph = FONT_5X7[code - FIRST_CODE];
        // five glyph columns, then the background gap column
        for (int col = 0; col <= GLYPH_COLS; col++) begin
            column_bits = (col < GLYPH_COLS) ? glyph[39 - 8 * col -: 8] : 8'h00;
            for (int row = 0; row < GLYPH_ROWS; row++) begin
                px = int'(text_x) + col;
                py = int'(text_y) + row;
                if (px < int'(model_width) && py < int'(model_height)) begin
                    if (have_held)
                        pending_pixels.push_back(held);
                    held.pixel_x      = 10'(px);
                    held.pixel_y      = 10'(py);
                    held.pixel_colour = column_bits[row] ? fg_latched : bg_latched;
                    held.last_of_char = 1'b0;
                    have_held         = 1'b1;
                end
            end
        end
        if (have_held) begin
            held.last_of_char = 1'b1;
            pending_pixels.push_back(held);
        end
        text_x = text_x + 11'(CELL_WIDTH);
    endfunction

    function automatic t_char make_char(input logic [7:0] code, input logic start,
                                        input logic [9:0] ox, input logic [9:0] oy,
                                        input logic [15:0] fg, input logic [15:0] bg);
        t_char ch;
        ch.char_code    = code;
        ch.string_start = start;
        ch.origin_x     = ox;
        ch.origin_y     = oy;
        ch.ink_color    = fg;
        ch.paper_color  = bg;
        return ch;
    endfunction

    function automatic t_char random_char();
        return make_char(8'($urandom), 1'($urandom), 10'($urandom), 10'($urandom),
                         16'($urandom), 16'($urandom));
    endfunction

    // one character transfer, with random idle cycles ahead of it
    task automatic send_char(input t_char ch);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ch;
        do @(posedge i_clk); while (o_in_stall);
        render_glyph_pixels(ch);
    endtask

    // wait until every expected pixel is out and dropped characters have retired
    task automatic wait_render_idle();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_panel_reg(input t_cfg_index idx, input logic [9:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_PANEL_WIDTH)
            model_width = value;
        else
            model_height = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // characters before any string start are dropped
    task automatic test_no_string_after_reset();
        send_char(make_char("A", 1'b0, 10'd0, 10'd0, 16'hFFFF, 16'h0000));
    endtask

    // both ends of the printable range and codes that fall back to '?'
    task automatic test_glyph_codes();
        send_char(make_char("!", 1'b1, 10'd0, 10'd0, 16'hFFFF, 16'h0000));
        send_char(make_char(FIRST_CODE, 1'b0, 10'd0, 10'd0, 16'h0000, 16'h0000));
        send_char(make_char(LAST_CODE, 1'b0, 10'd0, 10'd0, 16'h0000, 16'h0000));
        send_char(make_char(8'h01, 1'b0, 10'd0, 10'd0, 16'h0000, 16'h0000));
        send_char(make_char(8'h1F, 1'b0, 10'd0, 10'd0, 16'h0000, 16'h0000));
        send_char(make_char(8'h7F, 1'b0, 10'd0, 10'd0, 16'h0000, 16'h0000));
        send_char(make_char(8'h80, 1'b0, 10'd0, 10'd0, 16'h0000, 16'h0000));
        send_char(make_char(8'hFF, 1'b0, 10'd0, 10'd0, 16'h0000, 16'h0000));
    endtask

    // terminator with a start still latches; right edge wrap to the origin column
    task automatic test_terminator_and_wrap();
        send_char(make_char(END_CODE, 1'b1, 10'd10, 10'd20, 16'h1234, 16'h5678));
        send_char(make_char("B", 1'b0, 10'd0, 10'd0, 16'h0000, 16'h0000));
        send_char(make_char("C", 1'b1, 10'd130, 10'd0, 16'h0000, 16'hFFFF));
        send_char(make_char("D", 1'b0, 10'd0, 10'd0, 16'h0000, 16'h0000));
        send_char(make_char("E", 1'b0, 10'd0, 10'd0, 16'h0000, 16'h0000));
    endtask

    // origin too close to the right edge, full clipping, bottom edge stop
    task automatic test_panel_edges();
        send_char(make_char("F", 1'b1, 10'd140, 10'd0, 16'hA5A5, 16'h5A5A));
        send_char(make_char("G", 1'b0, 10'd0, 10'd0, 16'h0000, 16'h0000));
        send_char(make_char("H", 1'b1, 10'd500, 10'd0, 16'hA5A5, 16'h5A5A));
        send_char(make_char("I", 1'b1, 10'd0, 10'd421, 16'hF800, 16'h07E0));
        send_char(make_char("I", 1'b1, 10'd138, 10'd421, 16'hF800, 16'h07E0));
        send_char(make_char("J", 1'b0, 10'd0, 10'd0, 16'h0000, 16'h0000));
    endtask

    // smallest, below-range and largest panel settings
    task automatic test_panel_sizes();
        wait_render_idle();
        write_panel_reg(CFG_PANEL_WIDTH, 10'd6);
        write_panel_reg(CFG_PANEL_HEIGHT, 10'd7);
        send_char(make_char("K", 1'b1, 10'd0, 10'd0, 16'h001F, 16'hFFE0));
        send_char(make_char("L", 1'b0, 10'd0, 10'd0, 16'h0000, 16'h0000));
        wait_render_idle();
        write_panel_reg(CFG_PANEL_WIDTH, 10'd3);
        write_panel_reg(CFG_PANEL_HEIGHT, 10'd1000);
        send_char(make_char("M", 1'b1, 10'd0, 10'd0, 16'h001F, 16'hFFE0));
        wait_render_idle();
        write_panel_reg(CFG_PANEL_WIDTH, 10'd1023);
        write_panel_reg(CFG_PANEL_HEIGHT, 10'd1023);
        send_char(make_char("N", 1'b1, 10'd1015, 10'd1014, 16'hFFFF, 16'h0000));
        send_char(make_char("O", 1'b0, 10'd0, 10'd0, 16'h0000, 16'h0000));
        wait_render_idle();
        write_panel_reg(CFG_PANEL_WIDTH, 10'd0);
        write_panel_reg(CFG_PANEL_HEIGHT, 10'd0);
        send_char(make_char("P", 1'b1, 10'd0, 10'd0, 16'hFFFF, 16'h0000));
        wait_render_idle();
        write_panel_reg(CFG_PANEL_WIDTH, PANEL_WIDTH_RESET);
        write_panel_reg(CFG_PANEL_HEIGHT, PANEL_HEIGHT_RESET);
    endtask

    // mostly well-formed strings at random panel sizes, some raw noise
    task automatic test_random_text(input int n_items);
        int          sent;
        int          len;
        logic [9:0]  w;
        logic [9:0]  h;
        t_char       ch;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(3) == 0) begin
                wait_render_idle();
                case ($urandom_range(9))
                    0:       w = 10'd6;
                    1:       w = 10'd1000;
                    2:       w = 10'd1023;
                    3:       w = 10'($urandom_range(0, 5));
                    default: w = 10'($urandom_range(6, 300));
                endcase
                case ($urandom_range(9))
                    0:       h = 10'd7;
                    1:       h = 10'd1000;
                    2:       h = 10'd1023;
                    3:       h = 10'($urandom_range(0, 6));
                    default: h = 10'($urandom_range(7, 400));
                endcase
                write_panel_reg(CFG_PANEL_WIDTH, w);
                write_panel_reg(CFG_PANEL_HEIGHT, h);
            end
            if ($urandom_range(4) != 0) begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    ch = random_char();
                    ch.string_start = (k == 0);
                    if (k == 0 && $urandom_range(9) != 0) begin
                        ch.origin_x = 10'($urandom_range(0, (model_width > 0) ?
                                                            int'(model_width) - 1 : 0));
                        ch.origin_y = 10'($urandom_range(0, int'(model_height)));
                    end
                    if (k == len - 1 && $urandom_range(9) < 4)
                        ch.char_code = END_CODE;
                    else if ($urandom_range(9) != 0)
                        ch.char_code = 8'($urandom_range(FIRST_CODE, LAST_CODE));
                    else
                        ch.char_code = 8'($urandom_range(1, 255));
                    send_char(ch);
                    sent++;
                end
            end else begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    send_char(random_char());
                    sent++;
                end
            end
        end
    endtask

    // long output hold-off while characters keep coming, so the input backs up
    task automatic test_output_backlog();
        wait_render_idle();
        write_panel_reg(CFG_PANEL_WIDTH, PANEL_WIDTH_RESET);
        write_panel_reg(CFG_PANEL_HEIGHT, PANEL_HEIGHT_RESET);
        stall_hold_req = 600;
        send_char(make_char("W", 1'b1, 10'd0, 10'd0, 16'hFFFF, 16'h0841));
        for (int k = 0; k < 19; k++)
            send_char(make_char(8'($urandom_range(FIRST_CODE, LAST_CODE)), 1'b0,
                                10'($urandom), 10'($urandom), 16'($urandom), 16'($urandom)));
        wait_render_idle();
    endtask

    initial begin
        int settle;
        settle = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 17;
        recv_idle_pct = 64;
        test_no_string_after_reset();
        test_glyph_codes();
        test_terminator_and_wrap();
        test_panel_edges();
        test_panel_sizes();
        test_random_text(100);

        send_idle_pct = 64;
        recv_idle_pct = 17;
        test_random_text(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_text(90);
        test_output_backlog();

        // let the last pixels drain, bounded
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0 && settle < SETTLE_LIMIT) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            $display("%0t: %0d expected pixels never arrived", $time, pending_pixels.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("PASS text_glyph_pixel_renderer_top");
        else
            $display("FAIL text_glyph_pixel_renderer_top");
        $finish;
    end

endmodule
